FILE: design/luhn_pkg.sv
// Shared types and constants for the card number Luhn classifier.
// No dependencies; used by the interfaces, controller, datapath and top level.
package luhn_pkg;

   localparam int CARD_WIDTH   = 64;
   localparam int BCD_DIGITS   = 20;
   localparam int CONV_STEPS   = CARD_WIDTH;
   localparam int STEP_WIDTH   = $clog2(CONV_STEPS);
   localparam int IDX_WIDTH    = $clog2(BCD_DIGITS);
   localparam int COUNT_WIDTH  = 5;
   localparam int CLASS_WIDTH  = 2;

   typedef logic [CARD_WIDTH-1:0]         card_type;
   typedef logic [BCD_DIGITS-1:0][3:0]    bcd_type;
   typedef logic [CLASS_WIDTH-1:0]        class_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic [IDX_WIDTH-1:0]          idx_type;

   localparam class_type CLASS_INVALID   = 2'd0;
   localparam class_type CLASS_PREFIX_3X = 2'd1;
   localparam class_type CLASS_PREFIX_5X = 2'd2;
   localparam class_type CLASS_LEAD_4    = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic    load;
      logic    convert;
      logic    scan;
      logic    publish;
      idx_type digit_idx;
   } cmd_type;

   // Double a decimal digit and fold the two product digits into one sum.
   function automatic logic [3:0] double_fold(input logic [3:0] d);
      logic [4:0] twice;
      twice = {d, 1'b0};
      if (twice >= 5'd10) begin
         return 4'(twice - 5'd9);
      end
      return twice[3:0];
   endfunction

endpackage

FILE: design/luhn_req_if.sv
// Request channel carrying one card number per transaction.
// Depends on luhn_pkg.
interface luhn_req_if;
   logic               valid;
   logic               ready;
   luhn_pkg::card_type card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

FILE: design/luhn_rsp_if.sv
// Response channel carrying the class, Luhn flag and digit count.
// Depends on luhn_pkg.
interface luhn_rsp_if;
   logic                valid;
   logic                ready;
   luhn_pkg::class_type card_class;
   logic                luhn_ok;
   luhn_pkg::count_type digit_count;

   modport source (output valid, output card_class, output luhn_ok, output digit_count,
                   input ready);
   modport sink   (input valid, input card_class, input luhn_ok, input digit_count,
                   output ready);
endinterface

FILE: design/luhn_ctrl.sv
// Sequencer for the classifier: load, binary-to-BCD steps, digit scan, publish.
// Depends on luhn_pkg; drives the datapath through luhn_pkg::cmd_type.
module luhn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output luhn_pkg::cmd_type cmd
);

   luhn_pkg::state_type                 state_ff, state_in;
   logic [luhn_pkg::STEP_WIDTH-1:0]     step_ff, step_in;
   logic                                out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= luhn_pkg::ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.convert   = 1'b0;
      cmd.scan      = 1'b0;
      cmd.publish   = 1'b0;
      cmd.digit_idx = step_ff[luhn_pkg::IDX_WIDTH-1:0];
      unique case (state_ff)
         luhn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = luhn_pkg::ST_CONVERT;
            end
         end
         luhn_pkg::ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (step_ff == luhn_pkg::STEP_WIDTH'(luhn_pkg::CONV_STEPS - 1)) begin
               step_in  = '0;
               state_in = luhn_pkg::ST_SCAN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         luhn_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (step_ff == luhn_pkg::STEP_WIDTH'(luhn_pkg::BCD_DIGITS - 1)) begin
               step_in  = '0;
               state_in = luhn_pkg::ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         luhn_pkg::ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = luhn_pkg::ST_IDLE;
            end
         end
         default: state_in = luhn_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

FILE: design/luhn_dp.sv
// Datapath: shift-and-add-3 BCD converter, digit scan for Luhn sum and count,
// and the result register. Depends on luhn_pkg.
module luhn_dp #(
   parameter int MAX_DIGITS = 19
) (
   input  logic                clock,
   input  luhn_pkg::cmd_type   cmd,
   input  luhn_pkg::card_type  card_number,
   output luhn_pkg::class_type card_class,
   output logic                luhn_ok,
   output luhn_pkg::count_type digit_count
);

   luhn_pkg::card_type  bin_ff, bin_in;
   luhn_pkg::bcd_type   bcd_ff, bcd_in, bcd_adj;
   logic [3:0]          total_ff, total_in;
   luhn_pkg::count_type count_ff, count_in;
   logic                over_ff, over_in;
   luhn_pkg::class_type class_ff, class_in;
   logic                ok_ff, ok_in;
   luhn_pkg::count_type dcount_ff, dcount_in;

   logic [3:0]          digit;
   logic [3:0]          weighted;
   logic [4:0]          sum;

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      total_ff  <= total_in;
      count_ff  <= count_in;
      over_ff   <= over_in;
      class_ff  <= class_in;
      ok_ff     <= ok_in;
      dcount_ff <= dcount_in;
   end

   always_comb begin
      for (int i = 0; i < luhn_pkg::BCD_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? 4'(bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
   end

   assign digit    = bcd_ff[cmd.digit_idx];
   assign weighted = cmd.digit_idx[0] ? luhn_pkg::double_fold(digit) : digit;
   assign sum      = {1'b0, total_ff} + {1'b0, weighted};

   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      over_in   = over_ff;
      class_in  = class_ff;
      ok_in     = ok_ff;
      dcount_in = dcount_ff;
      if (cmd.load) begin
         bin_in   = card_number;
         bcd_in   = '0;
         total_in = '0;
         count_in = '0;
         over_in  = 1'b0;
      end else if (cmd.convert) begin
         {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
      end else if (cmd.scan) begin
         total_in = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
         if (digit != 4'd0) begin
            count_in = luhn_pkg::COUNT_WIDTH'(cmd.digit_idx) + 1'b1;
            if (luhn_pkg::COUNT_WIDTH'(cmd.digit_idx)
                >= luhn_pkg::COUNT_WIDTH'(MAX_DIGITS)) begin
               over_in = 1'b1;
            end
         end
      end else if (cmd.publish) begin
         if (over_ff) begin
            class_in  = luhn_pkg::CLASS_INVALID;
            ok_in     = 1'b0;
            dcount_in = luhn_pkg::COUNT_WIDTH'(MAX_DIGITS + 1);
         end else begin
            ok_in     = (total_ff == 4'd0);
            dcount_in = count_ff;
            class_in  = luhn_pkg::CLASS_INVALID;
            if (total_ff == 4'd0) begin
               priority if (count_ff == 5'd15 && bcd_ff[14] == 4'd3
                            && (bcd_ff[13] == 4'd4 || bcd_ff[13] == 4'd7)) begin
                  class_in = luhn_pkg::CLASS_PREFIX_3X;
               end else if (count_ff == 5'd16 && bcd_ff[15] == 4'd5
                            && bcd_ff[14] >= 4'd1 && bcd_ff[14] <= 4'd5) begin
                  class_in = luhn_pkg::CLASS_PREFIX_5X;
               end else if ((count_ff == 5'd13 && bcd_ff[12] == 4'd4)
                            || (count_ff == 5'd16 && bcd_ff[15] == 4'd4)) begin
                  class_in = luhn_pkg::CLASS_LEAD_4;
               end else begin
                  class_in = luhn_pkg::CLASS_INVALID;
               end
            end
         end
      end
   end

   assign card_class  = class_ff;
   assign luhn_ok     = ok_ff;
   assign digit_count = dcount_ff;

endmodule

FILE: design/card_number_luhn_classifier.sv
// Top level of the card number Luhn classifier.
// Depends on luhn_pkg, luhn_req_if, luhn_rsp_if, luhn_ctrl and luhn_dp.
//
// Usage:
//   req_bus carries one binary card number per transaction; rsp_bus returns
//   one transaction per request with the card class, the Luhn pass flag and
//   the decimal digit count. Numbers of 10^MAX_DIGITS or more report class 0,
//   luhn_ok 0 and a digit count of MAX_DIGITS + 1.
//   From acceptance to rsp valid each request goes through these steps: the
//   accepting edge loads the number, then 64 shift-and-add-3 steps of the
//   binary-to-BCD converter (one input bit per cycle), a scan of the 20 BCD
//   digits that builds the Luhn sum and the count, and a final state that
//   registers the result. One request is in work at a time and idle follows
//   the result, so a new request is taken only after the previous one is done.
//   The result sits in an output register: req_ready returns as soon as the
//   result is registered, so the next request can start while rsp waits.
//   If rsp_ready stays low, a finished request holds in the final state until
//   the output register frees up.
//   Synchronous active-high reset returns to idle and drops rsp valid; no
//   stored data needs clearing.
module card_number_luhn_classifier #(
   parameter int MAX_DIGITS = 19
) (
   input  logic       clock,
   input  logic       reset,
   luhn_req_if.sink   req_bus,
   luhn_rsp_if.source rsp_bus
);

   luhn_pkg::cmd_type cmd;

   luhn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   luhn_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .card_number (req_bus.card_number),
      .card_class  (rsp_bus.card_class),
      .luhn_ok     (rsp_bus.luhn_ok),
      .digit_count (rsp_bus.digit_count)
   );

endmodule
